FILE: src/adtf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adtf_pkg
// Shared types, constants and helper functions for the ascii decimal to
// fixed point converter.
// ----------------------------------------------------------------------------
package adtf_pkg;

  // fixed widths of the beat fields
  localparam int ByteW  = 8;
  localparam int ValueW = 54;

  // parameter defaults
  localparam int MaxKeptDefault  = 9;
  localparam int FracBitsDefault = 24;

  // distance from the latest point, holds up to the largest legal MaxKept
  localparam int KW = 4;

  // entries in the queue between front and back
  localparam int QueueDepth = 2;

  // character codes
  localparam logic [ByteW-1:0] ChNul   = 8'h00;
  localparam logic [ByteW-1:0] ChFF    = 8'hff;
  localparam logic [ByteW-1:0] ChZero  = 8'h30;
  localparam logic [ByteW-1:0] ChNine  = 8'h39;
  localparam logic [ByteW-1:0] ChPoint = 8'h2e;

  // work handed from front to back
  typedef enum logic [1:0] {
    OP_INT_DIGIT,
    OP_FRAC_DIGIT,
    OP_TERM
  } adtf_op_e;

  typedef struct packed {
    adtf_op_e        op;
    logic [3:0]      digit;
    logic [KW-1:0]   k;
    logic            trunc;
  } adtf_entry_t;

  // bits needed for an integer part of max_kept decimal digits
  function automatic int int_width(input int max_kept);
    longint unsigned p;
    int i;
    p = 1;
    for (i = 0; i < max_kept; i++) begin
      p = p * 10;
    end
    return $clog2(p);
  endfunction

  // round(2^frac_bits / 10^k), ties upward, evaluated at elaboration
  function automatic logic [63:0] weight_of(input int k, input int frac_bits);
    longint unsigned q;
    int i;
    q = longint'(1) << (frac_bits + 1);
    for (i = 0; i < k; i++) begin
      q = q / 10;
    end
    return 64'((q + 1) >> 1);
  endfunction

endpackage
`default_nettype wire

FILE: src/adtf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adtf_front
// Classifies text bytes, tracks kept count, point and digit position, and
// queues digit and terminator work for the back end.
// ----------------------------------------------------------------------------
module adtf_front import adtf_pkg::*; #(
  parameter int MaxKept = MaxKeptDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ByteW-1:0] text_byte_i,
  input  wire logic             q_full_i,
  output logic                  q_push_o,
  output adtf_entry_t           q_entry_o
);

  localparam int CntW = $clog2(MaxKept + 1);

  logic [CntW-1:0] kept_q, kept_d;
  logic [KW-1:0]   k_q, k_d;
  logic            point_q, point_d;
  logic            ovf_q, ovf_d;

  logic accept, is_term, is_digit, is_point, room;

  // classify the byte
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_term    = (text_byte_i == ChNul) || (text_byte_i == ChFF);
  assign is_digit   = (text_byte_i >= ChZero) && (text_byte_i <= ChNine);
  assign is_point   = (text_byte_i == ChPoint);
  assign room       = (kept_q < CntW'(MaxKept));

  // position tracking and queue entry
  always_comb begin
    kept_d          = kept_q;
    k_d             = k_q;
    point_d         = point_q;
    ovf_d           = ovf_q;
    q_push_o        = 1'b0;
    q_entry_o.op    = OP_TERM;
    q_entry_o.digit = 4'(text_byte_i - ChZero);
    q_entry_o.k     = k_q + KW'(1);
    q_entry_o.trunc = ovf_q;
    if (accept) begin
      if (is_term) begin
        q_push_o = 1'b1;
        kept_d   = '0;
        k_d      = '0;
        point_d  = 1'b0;
        ovf_d    = 1'b0;
      end else if (is_digit || is_point) begin
        if (!room) begin
          ovf_d = 1'b1;
        end else begin
          kept_d = kept_q + CntW'(1);
          if (is_point) begin
            point_d = 1'b1;
            k_d     = '0;
          end else if (!point_q) begin
            q_push_o     = 1'b1;
            q_entry_o.op = OP_INT_DIGIT;
          end else begin
            q_push_o     = 1'b1;
            q_entry_o.op = OP_FRAC_DIGIT;
            k_d          = k_q + KW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q  <= '0;
      k_q     <= '0;
      point_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      kept_q  <= kept_d;
      k_q     <= k_d;
      point_q <= point_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule
`default_nettype wire

FILE: src/adtf_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adtf_fifo
// Short queue of work entries between the front and the back end.
// ----------------------------------------------------------------------------
module adtf_fifo import adtf_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire adtf_entry_t  entry_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output adtf_entry_t       head_o,
  output logic              empty_o
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  adtf_entry_t     mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: src/adtf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adtf_back
// Accumulates integer and fraction parts from queued digits and, on a
// terminator, loads the saturated fixed-point result into the output register.
// ----------------------------------------------------------------------------
module adtf_back import adtf_pkg::*; #(
  parameter int MaxKept  = MaxKeptDefault,
  parameter int FracBits = FracBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire adtf_entry_t       head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [ValueW-1:0]      value_o,
  output logic                   truncated_o
);

  localparam int IntW  = int_width(MaxKept);
  localparam int FracW = FracBits + 4;
  localparam int RawW  = IntW + FracBits + 1;
  localparam int SumW  = (RawW > ValueW) ? RawW : ValueW + 1;

  logic [IntW-1:0]     int_q, int_d;
  logic [FracW-1:0]    frac_q, frac_d;
  logic                out_valid_q, out_valid_d;
  logic [ValueW-1:0]   value_q, value_d;
  logic                trunc_q, trunc_d;

  logic [FracBits-1:0] weight_tab [2**KW];
  logic [FracW-1:0]    product;
  logic [SumW-1:0]     sum;
  logic                out_free;

  // fraction weights per digit position
  for (genvar g = 0; g < 2**KW; g++) begin : g_weight
    assign weight_tab[g] = FracBits'(weight_of(g, FracBits));
  end

  assign product  = FracW'(head_i.digit * weight_tab[head_i.k]);
  assign sum      = (SumW'(int_q) << FracBits) + SumW'(frac_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = !empty_i && ((head_i.op != OP_TERM) || out_free);

  // accumulate and finish
  always_comb begin
    int_d       = int_q;
    frac_d      = frac_q;
    value_d     = value_q;
    trunc_d     = trunc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o) begin
      unique case (head_i.op)
        OP_INT_DIGIT: begin
          int_d = IntW'((int_q << 3) + (int_q << 1)) + IntW'(head_i.digit);
        end
        OP_FRAC_DIGIT: begin
          frac_d = frac_q + product;
        end
        OP_TERM: begin
          value_d     = (|sum[SumW-1:ValueW]) ? '1 : sum[ValueW-1:0];
          trunc_d     = head_i.trunc;
          out_valid_d = 1'b1;
          int_d       = '0;
          frac_d      = '0;
        end
        default: begin
          int_d = int_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q       <= '0;
      frac_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      int_q       <= int_d;
      frac_q      <= frac_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    trunc_q <= trunc_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign truncated_o = trunc_q;

endmodule
`default_nettype wire

FILE: src/ascii_decimal_to_fixed_point.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_decimal_to_fixed_point
// Parses decimal text one byte per beat into an unsigned fixed-point number
// with FracBits fraction bits, emitted when a 0x00 or 0xff byte ends it.
// ----------------------------------------------------------------------------
//  channel  | signals                        | direction | beat
//  ---------+--------------------------------+-----------+------------------
//  in       | in_valid_i in_ready_o          | to block  | one text byte
//           | text_byte_i                    |           |
//  out      | out_valid_o out_ready_i        | from block| one parsed number
//           | value_o truncated_o            |           |
//
//  One byte is taken every cycle while the queue is not full; the front
//  classifies it in its beat cycle and queues it, and the back takes it
//  from the queue (digit multiply-accumulate plus weight table product).
//  A terminator is queued, then its result loads the output register.
//  A result held by out_ready_i low stalls the two-entry queue only when a
//  terminator is at its head; input stops only when that queue is full.
//  Reset clears all parse state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ascii_decimal_to_fixed_point import adtf_pkg::*; #(
  parameter int MaxKept  = MaxKeptDefault,
  parameter int FracBits = FracBitsDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [ByteW-1:0]  text_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [ValueW-1:0]      value_o,
  output logic                   truncated_o
);

  logic        q_push, q_full, q_pop, q_empty;
  adtf_entry_t q_entry, q_head;

  // byte classification
  adtf_front #(
    .MaxKept (MaxKept)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .text_byte_i (text_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_entry)
  );

  // decoupling queue
  adtf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .head_o  (q_head),
    .empty_o (q_empty)
  );

  // arithmetic and result register
  adtf_back #(
    .MaxKept  (MaxKept),
    .FracBits (FracBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_o     (value_o),
    .truncated_o (truncated_o)
  );

endmodule
`default_nettype wire

FILE: src/adtf_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// adtf_checker
// Port-level checks: held results, and terminator beats matched to results.
// ----------------------------------------------------------------------------
module adtf_checker import adtf_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic [ByteW-1:0]  text_byte_i,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic [ValueW-1:0] value_o,
  input wire logic              truncated_o
);

  localparam int PendW = $clog2(QueueDepth + 2);

  logic [PendW-1:0] pend_q;
  logic             term_beat, out_beat;

  assign term_beat = in_valid_i && in_ready_o &&
                     ((text_byte_i == ChNul) || (text_byte_i == ChFF));
  assign out_beat  = out_valid_o && out_ready_i;

  // terminators accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (term_beat && !out_beat) begin
      pend_q <= pend_q + PendW'(1);
    end else if (out_beat && !term_beat) begin
      pend_q <= pend_q - PendW'(1);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) &&
    $stable(truncated_o))
    else $error("result changed while stalled");

  // no result without a terminator
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != '0)
    else $error("result without terminator");

  // pending results bounded by queue plus output register
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PendW'(QueueDepth + 1))
    else $error("too many pending terminators");

  // with no terminator pending, the back end drains and input is open
  a_ready_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == '0 |-> in_ready_o)
    else $error("input stalled with nothing pending");

endmodule

bind ascii_decimal_to_fixed_point adtf_checker u_adtf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .text_byte_i (text_byte_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .value_o     (value_o),
  .truncated_o (truncated_o)
);
`default_nettype wire
